// ===== hw/rtl/wncc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wncc_pkg: shared types and constants of the window correlation block
// window snapshot carried from the accumulator front to the finish unit
// ----------------------------------------------------------------------------
package wncc_pkg;

	localparam int QUEUE_DEPTH = 2;

	// variance floor is ceil(n^4 / 100000) = ((n^4 + FLOOR_BIAS) >> 5) * FLOOR_RCP >> 71
	localparam logic [63:0] FLOOR_BIAS = 64'd99999;
	localparam logic [59:0] FLOOR_RCP  = 60'd755578637259143235;

	localparam logic [15:0] Q_MAX   = 16'd32767;
	localparam logic [15:0] Q_LIMIT = 16'd32768;

	typedef struct packed {
		logic [15:0] n;
		logic [23:0] s1;
		logic [23:0] s2;
		logic [31:0] s11;
		logic [31:0] s22;
		logic [31:0] s12;
	} snap_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_PREP,
		BK_DIV,
		BK_WIDE,
		BK_SRCH,
		BK_OUT
	} back_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/wncc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wncc_front: pixel pair accumulator
// sums count, pixels, squares and cross products; pushes a snapshot on last
// ----------------------------------------------------------------------------
module wncc_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [7:0]      ref_pixel,
	input  wire logic [7:0]      search_pixel,
	input  wire logic            last_pixel,
	input  wire logic            full,
	output logic                 busy,
	output logic                 push,
	output wncc_pkg::snap_t      snap
);

	logic [15:0] n_q;
	logic [23:0] s1_q;
	logic [23:0] s2_q;
	logic [31:0] s11_q;
	logic [31:0] s22_q;
	logic [31:0] s12_q;
	logic [15:0] aa;
	logic [15:0] bb;
	logic [15:0] ab;
	logic        accept;

	assign busy   = full;
	assign accept = start && !full;
	assign push   = accept && last_pixel;

	assign aa = {8'b0, ref_pixel} * {8'b0, ref_pixel};
	assign bb = {8'b0, search_pixel} * {8'b0, search_pixel};
	assign ab = {8'b0, ref_pixel} * {8'b0, search_pixel};

	always_comb begin
		snap.n   = n_q + 16'd1;
		snap.s1  = s1_q + {16'b0, ref_pixel};
		snap.s2  = s2_q + {16'b0, search_pixel};
		snap.s11 = s11_q + {16'b0, aa};
		snap.s22 = s22_q + {16'b0, bb};
		snap.s12 = s12_q + {16'b0, ab};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			s1_q  <= '0;
			s2_q  <= '0;
			s11_q <= '0;
			s22_q <= '0;
			s12_q <= '0;
		end else if (accept) begin
			if (last_pixel) begin
				n_q   <= '0;
				s1_q  <= '0;
				s2_q  <= '0;
				s11_q <= '0;
				s22_q <= '0;
				s12_q <= '0;
			end else begin
				n_q   <= snap.n;
				s1_q  <= snap.s1;
				s2_q  <= snap.s2;
				s11_q <= snap.s11;
				s22_q <= snap.s22;
				s12_q <= snap.s12;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/wncc_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wncc_queue: snapshot queue
// small register queue between accumulator front and finish unit
// ----------------------------------------------------------------------------
module wncc_queue #(
	parameter int DEPTH = wncc_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wncc_pkg::snap_t      wdata,
	input  wire logic            pop,
	output wncc_pkg::snap_t      head,
	output logic                 full,
	output logic                 empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	wncc_pkg::snap_t mem_q [DEPTH];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [CW-1:0]   cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/wncc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wncc_back: correlation finish unit
// sequencer around one 32x32 multiplier: moments, floor by reciprocal,
// wide products and a bitwise search for the rounded Q1.15 quotient
// ----------------------------------------------------------------------------
module wncc_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            empty,
	input  wncc_pkg::snap_t      head,
	output logic                 pop,
	output logic                 done,
	output logic signed [15:0]   correlation
);

	wncc_pkg::back_state_t state_q, state_d;

	logic [15:0]        n_q;
	logic [23:0]        s1_q;
	logic [23:0]        s2_q;
	logic [31:0]        s11_q;
	logic [31:0]        s22_q;
	logic [31:0]        s12_q;
	logic [47:0]        t_q;
	logic signed [48:0] num_q;
	logic signed [48:0] v1_q;
	logic signed [48:0] v2_q;
	logic [31:0]        n2_q;
	logic [63:0]        dv_q;
	logic [47:0]        floor_q;
	logic [95:0]        prod_q;
	logic [95:0]        nsq_q;
	logic [95:0]        den_q;
	logic [31:0]        sq_q;
	logic [15:0]        q_q;
	logic [63:0]        mul_q;
	logic [127:0]       acc_q;
	logic [2:0]         step_q;
	logic               ph_q;
	logic [3:0]         bit_q;
	logic               done_q;
	logic [15:0]        corr_q;

	logic [31:0]  opa;
	logic [31:0]  opb;
	logic [1:0]   shsel;
	logic [127:0] shifted;
	logic [127:0] acc_next;
	logic [47:0]  mv1;
	logic [47:0]  mv2;
	logic [47:0]  mnum;
	logic         same_sign;
	logic [15:0]  cand;
	logic [16:0]  odd;
	logic         fit;
	logic [47:0]  src_a;
	logic [47:0]  src_b;
	logic [1:0]   dlimb;
	logic [15:0]  res;

	function automatic logic [31:0] limb(input logic [47:0] x, input logic hi);
		return hi ? {16'b0, x[47:32]} : x[31:0];
	endfunction

	function automatic logic [31:0] limb64(input logic [63:0] x, input logic hi);
		return hi ? x[63:32] : x[31:0];
	endfunction

	assign mv1  = v1_q[48] ? 48'(-v1_q) : v1_q[47:0];
	assign mv2  = v2_q[48] ? 48'(-v2_q) : v2_q[47:0];
	assign mnum = num_q[48] ? 48'(-num_q) : num_q[47:0];
	assign same_sign = (!v1_q[48] && v1_q != '0 && !v2_q[48] && v2_q != '0)
		|| (v1_q[48] && v2_q[48]);

	assign cand = q_q | (16'd1 << bit_q);
	assign odd  = {cand, 1'b0} - 17'd1;
	assign src_a = step_q[2] ? mnum : mv1;
	assign src_b = step_q[2] ? mnum : mv2;
	assign dlimb = step_q[1:0] - 2'd1;

	always_comb begin
		case (shsel)
			2'd1:    shifted = {32'b0, mul_q, 32'b0};
			2'd2:    shifted = {mul_q, 64'b0};
			default: shifted = {64'b0, mul_q};
		endcase
	end

	assign acc_next = acc_q + shifted;
	assign fit = (acc_next <= {nsq_q, 32'b0}) && (cand <= wncc_pkg::Q_LIMIT);

	always_comb begin
		if (num_q == '0) begin
			res = '0;
		end else if (!num_q[48]) begin
			res = (q_q > wncc_pkg::Q_MAX) ? wncc_pkg::Q_MAX : q_q;
		end else begin
			res = 16'd0 - q_q;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			wncc_pkg::BK_IDLE: if (!empty) state_d = wncc_pkg::BK_PREP;
			wncc_pkg::BK_PREP: if (ph_q && step_q == 3'd7) state_d = wncc_pkg::BK_DIV;
			wncc_pkg::BK_DIV:  if (ph_q && step_q == 3'd3) state_d = wncc_pkg::BK_WIDE;
			wncc_pkg::BK_WIDE: if (ph_q && step_q == 3'd7) state_d = wncc_pkg::BK_SRCH;
			wncc_pkg::BK_SRCH: begin
				if (ph_q && step_q[1:0] == 2'd3 && bit_q == 4'd0) begin
					state_d = wncc_pkg::BK_OUT;
				end
			end
			wncc_pkg::BK_OUT:  state_d = wncc_pkg::BK_IDLE;
			default:           state_d = wncc_pkg::BK_IDLE;
		endcase
	end

	// outputs and multiplier operands
	always_comb begin
		pop   = 1'b0;
		opa   = '0;
		opb   = '0;
		shsel = 2'd0;
		case (state_q)
			wncc_pkg::BK_IDLE: pop = !empty;
			wncc_pkg::BK_PREP: begin
				case (step_q)
					3'd0: begin opa = {16'b0, n_q}; opb = s12_q; end
					3'd1: begin opa = {8'b0, s1_q}; opb = {8'b0, s2_q}; end
					3'd2: begin opa = {16'b0, n_q}; opb = s11_q; end
					3'd3: begin opa = {8'b0, s1_q}; opb = {8'b0, s1_q}; end
					3'd4: begin opa = {16'b0, n_q}; opb = s22_q; end
					3'd5: begin opa = {8'b0, s2_q}; opb = {8'b0, s2_q}; end
					3'd6: begin opa = {16'b0, n_q}; opb = {16'b0, n_q}; end
					default: begin opa = n2_q; opb = n2_q; end
				endcase
			end
			wncc_pkg::BK_DIV: begin
				opa   = limb64({5'b0, dv_q[63:5]}, step_q[1]);
				opb   = limb64({4'b0, wncc_pkg::FLOOR_RCP}, step_q[0]);
				shsel = {1'b0, step_q[1]} + {1'b0, step_q[0]};
			end
			wncc_pkg::BK_WIDE: begin
				opa   = limb(src_a, step_q[1]);
				opb   = limb(src_b, step_q[0]);
				shsel = {1'b0, step_q[1]} + {1'b0, step_q[0]};
			end
			wncc_pkg::BK_SRCH: begin
				if (step_q[1:0] == 2'd0) begin
					opa = {15'b0, odd};
					opb = {15'b0, odd};
				end else begin
					opa   = sq_q;
					shsel = dlimb;
					case (dlimb)
						2'd0:    opb = den_q[31:0];
						2'd1:    opb = den_q[63:32];
						default: opb = den_q[95:64];
					endcase
				end
			end
			default: pop = 1'b0;
		endcase
	end

	assign done        = done_q;
	assign correlation = $signed(corr_q);

	always_ff @(posedge clk) begin
		mul_q <= {32'b0, opa} * {32'b0, opb};
		case (state_q)
			wncc_pkg::BK_IDLE: begin
				n_q   <= head.n;
				s1_q  <= head.s1;
				s2_q  <= head.s2;
				s11_q <= head.s11;
				s22_q <= head.s22;
				s12_q <= head.s12;
				acc_q <= '0;
				q_q   <= '0;
			end
			wncc_pkg::BK_PREP: begin
				if (ph_q) begin
					case (step_q)
						3'd1:    num_q <= $signed({1'b0, t_q}) - $signed({1'b0, mul_q[47:0]});
						3'd3:    v1_q  <= $signed({1'b0, t_q}) - $signed({1'b0, mul_q[47:0]});
						3'd5:    v2_q  <= $signed({1'b0, t_q}) - $signed({1'b0, mul_q[47:0]});
						3'd6:    n2_q  <= mul_q[31:0];
						3'd7:    dv_q  <= mul_q + wncc_pkg::FLOOR_BIAS;
						default: t_q   <= mul_q[47:0];
					endcase
				end
			end
			wncc_pkg::BK_DIV: begin
				if (ph_q) begin
					if (step_q == 3'd3) begin
						floor_q <= acc_next[118:71];
						acc_q   <= '0;
					end else begin
						acc_q <= acc_next;
					end
				end
			end
			wncc_pkg::BK_WIDE: begin
				if (ph_q) begin
					if (step_q == 3'd3) begin
						prod_q <= acc_next[95:0];
						acc_q  <= '0;
					end else if (step_q == 3'd7) begin
						nsq_q <= acc_next[95:0];
						acc_q <= '0;
						den_q <= (same_sign && prod_q > {48'b0, floor_q}) ? prod_q
							: {48'b0, floor_q};
					end else begin
						acc_q <= acc_next;
					end
				end
			end
			wncc_pkg::BK_SRCH: begin
				if (ph_q) begin
					if (step_q[1:0] == 2'd0) begin
						sq_q  <= mul_q[31:0];
						acc_q <= '0;
					end else if (step_q[1:0] == 2'd3) begin
						acc_q <= '0;
						if (fit) begin
							q_q <= cand;
						end
					end else begin
						acc_q <= acc_next;
					end
				end
			end
			wncc_pkg::BK_OUT: corr_q <= res;
			default: acc_q <= acc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wncc_pkg::BK_IDLE;
			step_q  <= '0;
			ph_q    <= 1'b0;
			bit_q   <= 4'd15;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == wncc_pkg::BK_OUT);
			case (state_q)
				wncc_pkg::BK_IDLE: begin
					step_q <= '0;
					ph_q   <= 1'b0;
					bit_q  <= 4'd15;
				end
				wncc_pkg::BK_PREP, wncc_pkg::BK_WIDE: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						step_q <= step_q + 3'd1;
					end
				end
				wncc_pkg::BK_DIV: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						step_q <= (step_q == 3'd3) ? 3'd0 : step_q + 3'd1;
					end
				end
				wncc_pkg::BK_SRCH: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (step_q[1:0] == 2'd3) begin
							step_q <= '0;
							bit_q  <= bit_q - 4'd1;
						end else begin
							step_q <= step_q + 3'd1;
						end
					end
				end
				default: step_q <= '0;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/window_normalized_cross_correlation.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// window_normalized_cross_correlation: windowed normalized cross correlation
// ----------------------------------------------------------------------------
// Usage:
//   Drive one reference/search pixel pair per beat with start; a beat is
//   taken at a clock edge where start is high and busy is low. last_pixel
//   marks the final pair of a window and closes it.
//   The accumulators take one pair every cycle while busy is low. A closed
//   window goes into a two-entry queue in front of a shared-multiplier
//   finish unit, which works through the floor reciprocal product and a
//   16-step quotient search for each window and takes the next window from
//   the queue only once it is through with the current one. busy is high
//   only while that queue is full.
//   The result comes out on correlation with done high for exactly one
//   cycle; the receiver cannot stall it.
//   Reset clears the accumulators, empties the queue and aborts any window
//   in progress; no result is produced for it.
// ----------------------------------------------------------------------------
module window_normalized_cross_correlation #(
	parameter int QUEUE_DEPTH = wncc_pkg::QUEUE_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [7:0]          ref_pixel,
	input  wire logic [7:0]          search_pixel,
	input  wire logic                last_pixel,
	output logic                     done,
	output logic signed [15:0]       correlation
);

	wncc_pkg::snap_t wdata;
	wncc_pkg::snap_t head;
	logic            push;
	logic            pop;
	logic            full;
	logic            empty;

	wncc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.ref_pixel    (ref_pixel),
		.search_pixel (search_pixel),
		.last_pixel   (last_pixel),
		.full         (full),
		.busy         (busy),
		.push         (push),
		.snap         (wdata)
	);

	wncc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wdata),
		.pop    (pop),
		.head   (head),
		.full   (full),
		.empty  (empty)
	);

	wncc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (empty),
		.head        (head),
		.pop         (pop),
		.done        (done),
		.correlation (correlation)
	);

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> !empty) else $error("pushed window lost");

	a_pop_once: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> !pop) else $error("finish unit popped twice in a row");

endmodule
`default_nettype wire
